// File: src/assert_macros.svh
// Assertion shorthands; both sample on clk and stay quiet while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define PCT_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pct assertion failed");

// Next-cycle implication.
`define PCT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pct assertion failed");

`endif

// File: src/pct_pkg.sv
`default_nettype none
package pct_pkg;

	localparam int SLOT_COUNT_DEF = 20;
	localparam int MAX_RESULTS    = 20;

	localparam int REQ_W    = 2;
	localparam int HANDLE_W = 8;
	localparam int MS_W     = 16;
	localparam int KIND_W   = 3;
	localparam int SLOT_W   = 5;
	localparam int PER_W    = 11;
	localparam int FC_W     = $clog2(MAX_RESULTS + 1);

	localparam logic [REQ_W-1:0] REQ_TICK   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_ADD    = 2'd1;
	localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;

	localparam logic [KIND_W-1:0] KIND_FIRE     = 3'd0;
	localparam logic [KIND_W-1:0] KIND_ADDED    = 3'd1;
	localparam logic [KIND_W-1:0] KIND_FULL     = 3'd2;
	localparam logic [KIND_W-1:0] KIND_SMALL    = 3'd3;
	localparam logic [KIND_W-1:0] KIND_REMOVED  = 3'd4;
	localparam logic [KIND_W-1:0] KIND_NOTFOUND = 3'd5;

	// Tick length in ms; x/50 is taken as (x * 83887) >> 22, exact for 16-bit x.
	localparam logic [MS_W-1:0] TICK_MS    = 16'd50;
	localparam int              DIV_MUL_W  = 17;
	localparam logic [DIV_MUL_W-1:0] DIV_MUL = 17'd83887;
	localparam int              DIV_SHIFT  = 22;

endpackage
`default_nettype wire

// File: src/pct_in_if.sv
`default_nettype none
interface pct_in_if;
	import pct_pkg::*;

	logic                valid;
	logic                ready;
	logic [REQ_W-1:0]    req_type;
	logic [HANDLE_W-1:0] handle;
	logic [MS_W-1:0]     period_ms;

	modport source (output valid, req_type, handle, period_ms, input ready);
	modport sink (input valid, req_type, handle, period_ms, output ready);
endinterface
`default_nettype wire

// File: src/pct_out_if.sv
`default_nettype none
interface pct_out_if;
	import pct_pkg::*;

	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic [HANDLE_W-1:0] handle_out;
	logic [SLOT_W-1:0]   slot_index;
	logic                last;

	modport source (output valid, kind, handle_out, slot_index, last, input ready);
	modport sink (input valid, kind, handle_out, slot_index, last, output ready);
endinterface
`default_nettype wire

// File: src/periodic_callback_table.sv
// Flow: a request is accepted in idle; add and remove then walk the table one slot memory
// read per cycle until a hit or the end, and a tick walks it all; a too-short add or a remove
// of handle 0 skips the walk. A new request is taken only once the block is back in idle,
// after its last result has been registered.
// A result transfer held off by the sink stalls the walk.
// Reset: arst_n clears control state and the slot valid bits at once; no clearing pass.
`default_nettype none
module periodic_callback_table #(
	parameter int SLOT_COUNT = pct_pkg::SLOT_COUNT_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	pct_in_if.sink   req_ch,
	pct_out_if.source res_ch
);
	import pct_pkg::*;

	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CNT_W = $clog2(SLOT_COUNT + 1);
	localparam int TIM_W = 2 * PER_W;
	localparam int PROD_W = MS_W + DIV_MUL_W;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	state_t state_q;

	logic [REQ_W-1:0]    req_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [PER_W-1:0]    period_q;
	logic [CNT_W-1:0]    rd_idx_q;
	logic [FC_W-1:0]     fire_cnt_q;
	logic [SLOT_COUNT-1:0] slot_vld_q;

	// slot memories: owner handle, and {period, counter}
	logic [HANDLE_W-1:0] owner_mem [SLOT_COUNT];
	logic [TIM_W-1:0]    tim_mem [SLOT_COUNT];

	logic                vld_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic [HANDLE_W-1:0] owner_s1;
	logic                owner_ok_s1;
	logic [TIM_W-1:0]    tim_s1;

	// one result waiting for its last flag
	logic                pend_vld_q;
	logic [KIND_W-1:0]   pend_kind_q;
	logic [HANDLE_W-1:0] pend_handle_q;
	logic [IDX_W-1:0]    pend_idx_q;

	logic                res_vld_q;
	logic [KIND_W-1:0]   res_kind_q;
	logic [HANDLE_W-1:0] res_handle_q;
	logic [SLOT_W-1:0]   res_slot_q;
	logic                res_last_q;

	logic [PROD_W-1:0]   prod;
	logic [PER_W-1:0]    period_d;
	logic                too_short;
	logic [IDX_W-1:0]    rd_addr;
	logic [HANDLE_W-1:0] owner_eff;
	logic [PER_W-1:0]    cnt_rd;
	logic [PER_W-1:0]    per_rd;
	logic [PER_W-1:0]    cnt_new;
	logic                busy;
	logic                hit_fire;
	logic                emit_fire;
	logic                add_hit;
	logic                rem_hit;
	logic                s1_end;
	logic                out_free;
	logic                need_out;
	logic                stall;
	logic                eval;
	logic                issue;
	logic                res_push;
	logic                own_we;
	logic [HANDLE_W-1:0] own_wd;
	logic                tim_we;
	logic [TIM_W-1:0]    tim_wd;

	assign prod      = PROD_W'(req_ch.period_ms) * PROD_W'(DIV_MUL);
	assign period_d  = PER_W'(prod >> DIV_SHIFT);
	assign too_short = req_ch.period_ms <= TICK_MS;

	assign rd_addr   = rd_idx_q[IDX_W-1:0];
	assign owner_eff = owner_ok_s1 ? owner_s1 : '0;
	assign per_rd    = tim_s1[TIM_W-1:PER_W];
	assign cnt_rd    = tim_s1[PER_W-1:0];
	assign busy      = owner_eff != '0;
	assign hit_fire  = (req_q == REQ_TICK) && busy && (cnt_rd == per_rd);
	assign emit_fire = hit_fire && (fire_cnt_q < FC_W'(MAX_RESULTS));
	assign add_hit   = (req_q == REQ_ADD) && !busy;
	assign rem_hit   = (req_q == REQ_REMOVE) && (owner_eff == handle_q);
	assign cnt_new   = hit_fire ? PER_W'(1) : cnt_rd + PER_W'(1);
	assign s1_end    = idx_s1 == IDX_W'(SLOT_COUNT - 1);

	assign out_free = !res_vld_q || res_ch.ready;
	assign need_out = (emit_fire && pend_vld_q) || add_hit || rem_hit;
	assign stall    = vld_s1 && need_out && !out_free;
	assign eval     = (state_q == ST_SCAN) && vld_s1 && !stall;
	assign issue    = (state_q == ST_SCAN) && !stall && (rd_idx_q < CNT_W'(SLOT_COUNT));
	assign res_push = (eval && need_out) || ((state_q == ST_FINISH) && out_free);

	assign own_we = eval && (add_hit || rem_hit);
	assign own_wd = add_hit ? handle_q : '0;
	assign tim_we = eval && (add_hit || ((req_q == REQ_TICK) && busy));
	assign tim_wd = add_hit ? {period_q, PER_W'(0)} : {per_rd, cnt_new};

	assign req_ch.ready      = state_q == ST_IDLE;
	assign res_ch.valid      = res_vld_q;
	assign res_ch.kind       = res_kind_q;
	assign res_ch.handle_out = res_handle_q;
	assign res_ch.slot_index = res_slot_q;
	assign res_ch.last       = res_last_q;

	// read stalls with issue low, so the read registers hold their slot
	always_ff @(posedge clk) begin
		if (own_we) begin
			owner_mem[idx_s1] <= own_wd;
		end
		if (tim_we) begin
			tim_mem[idx_s1] <= tim_wd;
		end
		if (issue) begin
			owner_s1    <= owner_mem[rd_addr];
			tim_s1      <= tim_mem[rd_addr];
			owner_ok_s1 <= slot_vld_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			req_q         <= '0;
			handle_q      <= '0;
			period_q      <= '0;
			rd_idx_q      <= '0;
			fire_cnt_q    <= '0;
			slot_vld_q    <= '0;
			vld_s1        <= 1'b0;
			idx_s1        <= '0;
			pend_vld_q    <= 1'b0;
			pend_kind_q   <= '0;
			pend_handle_q <= '0;
			pend_idx_q    <= '0;
			res_vld_q     <= 1'b0;
			res_kind_q    <= '0;
			res_handle_q  <= '0;
			res_slot_q    <= '0;
			res_last_q    <= 1'b0;
		end else begin
			if (res_ch.ready && !res_push) begin
				res_vld_q <= 1'b0;
			end
			if (own_we && add_hit) begin
				slot_vld_q[idx_s1] <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					vld_s1 <= 1'b0;
					if (req_ch.valid) begin
						req_q      <= req_ch.req_type;
						handle_q   <= req_ch.handle;
						period_q   <= period_d;
						rd_idx_q   <= '0;
						fire_cnt_q <= '0;
						pend_handle_q <= req_ch.handle;
						pend_idx_q    <= '0;
						priority if (req_ch.req_type == REQ_TICK) begin
							state_q <= ST_SCAN;
						end else if (req_ch.req_type == REQ_ADD) begin
							if (too_short) begin
								pend_vld_q  <= 1'b1;
								pend_kind_q <= KIND_SMALL;
								state_q     <= ST_FINISH;
							end else begin
								state_q <= ST_SCAN;
							end
						end else if (req_ch.req_type == REQ_REMOVE) begin
							if (req_ch.handle == '0) begin
								pend_vld_q  <= 1'b1;
								pend_kind_q <= KIND_NOTFOUND;
								state_q     <= ST_FINISH;
							end else begin
								state_q <= ST_SCAN;
							end
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_SCAN: begin
					if (!stall) begin
						vld_s1 <= issue;
						idx_s1 <= rd_addr;
						if (issue) begin
							rd_idx_q <= rd_idx_q + CNT_W'(1);
						end
					end
					if (eval) begin
						priority if (add_hit || rem_hit) begin
							res_vld_q    <= 1'b1;
							res_kind_q   <= add_hit ? KIND_ADDED : KIND_REMOVED;
							res_handle_q <= handle_q;
							res_slot_q   <= SLOT_W'(idx_s1);
							res_last_q   <= 1'b1;
							state_q      <= ST_IDLE;
						end else if (req_q == REQ_TICK) begin
							if (emit_fire) begin
								fire_cnt_q <= fire_cnt_q + FC_W'(1);
								// push the previous fire, hold this one until the walk decides last
								if (pend_vld_q) begin
									res_vld_q    <= 1'b1;
									res_kind_q   <= pend_kind_q;
									res_handle_q <= pend_handle_q;
									res_slot_q   <= SLOT_W'(pend_idx_q);
									res_last_q   <= 1'b0;
								end
								pend_vld_q    <= 1'b1;
								pend_kind_q   <= KIND_FIRE;
								pend_handle_q <= owner_eff;
								pend_idx_q    <= idx_s1;
							end
							if (s1_end) begin
								state_q <= (pend_vld_q || emit_fire) ? ST_FINISH : ST_IDLE;
							end
						end else if (s1_end) begin
							pend_vld_q    <= 1'b1;
							pend_kind_q   <= (req_q == REQ_ADD) ? KIND_FULL : KIND_NOTFOUND;
							pend_handle_q <= handle_q;
							pend_idx_q    <= '0;
							state_q       <= ST_FINISH;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_FINISH: begin
					vld_s1 <= 1'b0;
					if (out_free) begin
						res_vld_q    <= 1'b1;
						res_kind_q   <= pend_kind_q;
						res_handle_q <= pend_handle_q;
						res_slot_q   <= SLOT_W'(pend_idx_q);
						res_last_q   <= 1'b1;
						pend_vld_q   <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// File: src/pct_checker.sv
`default_nettype none
`include "assert_macros.svh"
module pct_checker #(
	parameter int SLOT_COUNT = pct_pkg::SLOT_COUNT_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic [pct_pkg::REQ_W-1:0]     req_type,
	input logic                          res_valid,
	input logic                          res_ready,
	input logic [pct_pkg::KIND_W-1:0]    kind,
	input logic [pct_pkg::HANDLE_W-1:0]  handle_out,
	input logic [pct_pkg::SLOT_W-1:0]    slot_index,
	input logic                          last
);
	import pct_pkg::*;

	logic req_xfer;
	logic req_known;
	logic err_kind;
	logic [KIND_W+HANDLE_W+SLOT_W:0] res_data;

	assign req_xfer  = req_valid && req_ready && SLOT_COUNT > 0;
	assign req_known = (req_type == REQ_TICK) || (req_type == REQ_ADD) ||
		(req_type == REQ_REMOVE);
	assign err_kind  = (kind == KIND_FULL) || (kind == KIND_SMALL) ||
		(kind == KIND_NOTFOUND);
	assign res_data  = {kind, handle_out, slot_index, last};

	`PCT_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_data))
	`PCT_ASSERT_IMPL(a_err_slot_zero, res_valid && err_kind, slot_index == '0)
	`PCT_ASSERT_IMPL(a_single_is_last, res_valid && (kind != KIND_FIRE), last)
	`PCT_ASSERT_NEXT(a_busy_after_req, req_xfer && req_known, !req_ready)

endmodule

bind periodic_callback_table pct_checker #(.SLOT_COUNT(SLOT_COUNT)) u_pct_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req_ch.valid),
	.req_ready  (req_ch.ready),
	.req_type   (req_ch.req_type),
	.res_valid  (res_ch.valid),
	.res_ready  (res_ch.ready),
	.kind       (res_ch.kind),
	.handle_out (res_ch.handle_out),
	.slot_index (res_ch.slot_index),
	.last       (res_ch.last)
);
`default_nettype wire

// File: bench/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import pct_pkg::*;

	localparam int NSLOT            = SLOT_COUNT_DEF;
	localparam int CYCLE_LIMIT      = 500000;
	localparam int DRAIN_CYCLES     = NSLOT + 8;
	localparam int RANDOM_PER_PHASE = 80;
	localparam int HOLD_OFF_CYCLES  = 400;
	localparam int MAX_REPORTS      = 40;

	// req_type code the block must ignore
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [HANDLE_W-1:0] handle;
		logic [SLOT_W-1:0]   slot;
		logic                last;
	} timer_result_t;

	logic clk;
	logic arst_n;

	pct_in_if  req_ch ();
	pct_out_if res_ch ();

	periodic_callback_table #(.SLOT_COUNT(NSLOT)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req_ch (req_ch),
		.res_ch (res_ch)
	);

	// Shadow copy of the timer table
	logic [HANDLE_W-1:0] slot_owner  [NSLOT];
	logic [PER_W-1:0]    slot_period [NSLOT];
	logic [PER_W-1:0]    slot_count  [NSLOT];
	timer_result_t       results_due [$];

	int mismatches     = 0;
	int requests_taken = 0;
	int results_seen   = 0;
	int fires_seen     = 0;
	int send_idle_pct  = 0;
	int sink_stall_pct = 0;
	int hold_cycles    = 0;
	int cycles         = 0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("periodic_callback_table: mismatch");
			$finish;
		end
	end

	// Work out the results one request causes and advance the shadow table.
	function automatic void update_timer_table(logic [REQ_W-1:0] req,
		logic [HANDLE_W-1:0] h, logic [MS_W-1:0] ms);
		timer_result_t fired [$];
		timer_result_t r;
		bit            done;
		done = 1'b0;
		case (req)
			REQ_TICK: begin
				for (int i = 0; i < NSLOT; i++) begin
					if (slot_owner[i] != '0) begin
						if (slot_count[i] == slot_period[i]) begin
							if (fired.size() < MAX_RESULTS)
								fired.push_back('{KIND_FIRE, slot_owner[i], SLOT_W'(i), 1'b0});
							slot_count[i] = '0;
						end
						slot_count[i] = slot_count[i] + PER_W'(1);
					end
				end
				if (fired.size() > 0)
					fired[fired.size() - 1].last = 1'b1;
				foreach (fired[k])
					results_due.push_back(fired[k]);
			end
			REQ_ADD: begin
				r = '{KIND_FULL, h, '0, 1'b1};
				if (ms <= TICK_MS) begin
					r.kind = KIND_SMALL;
				end else begin
					for (int i = 0; i < NSLOT && !done; i++) begin
						if (slot_owner[i] == '0) begin
							slot_owner[i]  = h;
							slot_period[i] = PER_W'(ms / TICK_MS);
							slot_count[i]  = '0;
							r = '{KIND_ADDED, h, SLOT_W'(i), 1'b1};
							done = 1'b1;
						end
					end
				end
				results_due.push_back(r);
			end
			REQ_REMOVE: begin
				r = '{KIND_NOTFOUND, h, '0, 1'b1};
				if (h != '0) begin
					for (int i = 0; i < NSLOT && !done; i++) begin
						if (slot_owner[i] == h) begin
							slot_owner[i] = '0;
							r = '{KIND_REMOVED, h, SLOT_W'(i), 1'b1};
							done = 1'b1;
						end
					end
				end
				results_due.push_back(r);
			end
			default: ;
		endcase
	endfunction

	// Check result transfers first, then predict from request transfers.
	always @(posedge clk) begin : result_check
		timer_result_t got;
		timer_result_t want;
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				got = '{res_ch.kind, res_ch.handle_out, res_ch.slot_index, res_ch.last};
				results_seen++;
				if (got.kind == KIND_FIRE)
					fires_seen++;
				if (results_due.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: expected no result, got k%0d h%0d s%0d l%0d",
							$time, got.kind, got.handle, got.slot, got.last);
				end else begin
					want = results_due.pop_front();
					if (got.kind !== want.kind || got.handle !== want.handle ||
						got.slot !== want.slot || got.last !== want.last) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("%0t: expected k%0d h%0d s%0d l%0d, got k%0d h%0d s%0d l%0d",
								$time, want.kind, want.handle, want.slot, want.last,
								got.kind, got.handle, got.slot, got.last);
					end
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				requests_taken++;
				update_timer_table(req_ch.req_type, req_ch.handle, req_ch.period_ms);
			end
		end
	end

	// Sink side: count down a hold-off, otherwise stall at random.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			res_ch.ready <= 1'b0;
			hold_cycles--;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	task automatic send_request(logic [REQ_W-1:0] req, logic [HANDLE_W-1:0] h,
		logic [MS_W-1:0] ms);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.req_type  <= req;
		req_ch.handle    <= h;
		req_ch.period_ms <= ms;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// Drop valid, then let every outstanding result and any silent walk finish.
	task automatic drain();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send_random_request();
		logic [REQ_W-1:0]    req;
		logic [HANDLE_W-1:0] h;
		logic [MS_W-1:0]     ms;
		int                  roll;
		int                  busy;
		int                  pick;
		bit                  found;
		busy  = 0;
		found = 1'b0;
		foreach (slot_owner[i])
			if (slot_owner[i] != '0)
				busy++;
		h    = HANDLE_W'($urandom_range(255, 1));
		roll = $urandom_range(99);
		if (roll < 10)
			ms = MS_W'($urandom_range(50));
		else if (roll < 80)
			ms = MS_W'($urandom_range(500, 51));
		else
			ms = MS_W'($urandom_range(65535));
		roll = $urandom_range(99);
		if (roll < 3) begin
			req = REQ_UNUSED;
		end else if (roll < 48) begin
			req = REQ_TICK;
		end else if (roll < (busy < 10 ? 80 : 65)) begin
			req = REQ_ADD;
		end else begin
			req = REQ_REMOVE;
			// mostly aim at a handle that is in the table
			if ($urandom_range(99) < 75) begin
				pick = $urandom_range(NSLOT - 1);
				for (int i = 0; i < NSLOT && !found; i++) begin
					if (slot_owner[(pick + i) % NSLOT] != '0) begin
						h = slot_owner[(pick + i) % NSLOT];
						found = 1'b1;
					end
				end
			end
		end
		send_request(req, h, ms);
	endtask

	task automatic test_directed();
		send_request(REQ_TICK, 8'd0, 16'd0);
		send_request(REQ_REMOVE, 8'd5, 16'd0);
		send_request(REQ_ADD, 8'd1, 16'd0);
		send_request(REQ_ADD, 8'd1, 16'd50);
		send_request(REQ_ADD, 8'd0, 16'd100);
		send_request(REQ_REMOVE, 8'd0, 16'd0);
		send_request(REQ_UNUSED, 8'hFF, 16'hFFFF);
		send_request(REQ_ADD, 8'hFF, 16'd51);
		send_request(REQ_ADD, 8'hAA, 16'hFFFF);
		send_request(REQ_ADD, 8'h55, 16'd100);
		send_request(REQ_ADD, 8'h80, 16'd99);
		repeat (4) send_request(REQ_TICK, 8'h00, 16'h0000);
		send_request(REQ_REMOVE, 8'h55, 16'd0);
		send_request(REQ_REMOVE, 8'h55, 16'd0);
		send_request(REQ_ADD, 8'h01, 16'd150);
		repeat (2) send_request(REQ_TICK, 8'hFF, 16'hFFFF);
		send_request(REQ_REMOVE, 8'hFF, 16'd0);
		send_request(REQ_REMOVE, 8'hAA, 16'd0);
		send_request(REQ_REMOVE, 8'h80, 16'd0);
		send_request(REQ_REMOVE, 8'h01, 16'd0);
		drain();
	endtask

	task automatic test_full_table();
		// one add more than there are slots guarantees a full report
		for (int k = 0; k <= NSLOT; k++)
			send_request(REQ_ADD, HANDLE_W'(101 + k), MS_W'(51 + 25 * (k % 4)));
		send_request(REQ_ADD, 8'd77, 16'd50);
		repeat (3) send_request(REQ_TICK, 8'd0, 16'd0);
		send_request(REQ_REMOVE, 8'd110, 16'd0);
		send_request(REQ_ADD, 8'd240, 16'd60);
		send_request(REQ_TICK, 8'd0, 16'd0);
		for (int k = 0; k <= NSLOT; k++)
			send_request(REQ_REMOVE, HANDLE_W'(101 + k), 16'd0);
		send_request(REQ_REMOVE, 8'd240, 16'd0);
		drain();
	endtask

	task automatic test_sink_hold_off();
		send_idle_pct  = 0;
		sink_stall_pct = 0;
		hold_cycles    = HOLD_OFF_CYCLES;
		for (int k = 0; k < 6; k++)
			send_request(REQ_ADD, HANDLE_W'(200 + k), 16'd51);
		repeat (24) send_request(REQ_TICK, 8'd0, 16'd0);
		drain();
	endtask

	task automatic test_random(int idle_pct, int stall_pct);
		send_idle_pct  = idle_pct;
		sink_stall_pct = stall_pct;
		repeat (RANDOM_PER_PHASE) send_random_request();
		drain();
	endtask

	initial begin
		foreach (slot_owner[i]) begin
			slot_owner[i]  = '0;
			slot_period[i] = '0;
			slot_count[i]  = '0;
		end
		arst_n           = 1'b0;
		req_ch.valid     = 1'b0;
		req_ch.req_type  = REQ_TICK;
		req_ch.handle    = '0;
		req_ch.period_ms = '0;
		res_ch.ready     = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_full_table();
		test_sink_hold_off();
		test_random(0, 0);
		test_random(45, 0);
		test_random(0, 45);
		test_random(19, 19);

		$display("run covered %0d requests and %0d checked results, %0d of them fires,",
			requests_taken, results_seen, fires_seen);
		$display("over a full table, a %0d-cycle sink hold-off and four idle/stall mixes",
			HOLD_OFF_CYCLES);
		if (mismatches == 0)
			$display("periodic_callback_table: match");
		else
			$display("periodic_callback_table: mismatch");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+src
src/pct_pkg.sv
src/pct_in_if.sv
src/pct_out_if.sv
src/periodic_callback_table.sv
src/pct_checker.sv
bench/tb.sv
